### rtl/ieic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieic_pkg: shared types and constants
// Buffer geometry, operation codes, capture phases and the result word
// format shared by the edge interval capture block.
// ----------------------------------------------------------------------------
package ieic_pkg;

  // interval buffer geometry
  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // gap limit after reset, in microseconds
  localparam logic [19:0] GAP_LIMIT_RESET = 20'd10000;

  // operation codes of an input word
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // reported capture state codes
  localparam logic [1:0] CS_IDLE    = 2'd0;
  localparam logic [1:0] CS_RUNNING = 2'd1;
  localparam logic [1:0] CS_STOPPED = 2'd2;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // capture phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_RUNNING = 3'b010,
    PH_STOPPED = 3'b100
  } phase_t;

  // one result word
  typedef struct packed {
    logic [1:0]  capture_state;
    logic [7:0]  entry_count;
    logic        done_res;
    logic [31:0] read_value;
  } res_word_t;

  // result fields held alongside the buffer read
  typedef struct packed {
    logic [1:0] capture_state;
    logic [7:0] entry_count;
    logic       done_res;
    logic       is_read;
  } res_meta_t;

  // status of the result queue seen by the front end
  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              empty;
  } q_status_t;

  // phase to reported code
  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE:    code = CS_IDLE;
      PH_RUNNING: code = CS_RUNNING;
      default:    code = CS_STOPPED;
    endcase
    return code;
  endfunction

endpackage

### rtl/ieic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieic_front: word intake and capture state
// Accepts input words, updates phase, timestamp and count, stores
// intervals in the buffer and reads them back, then hands one result
// word per input word to the result queue.
// ----------------------------------------------------------------------------
module ieic_front import ieic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_time_us,
  input  logic        in_pin_level,
  input  logic [6:0]  in_read_index,
  // gap limit register
  input  logic        cfg_we,
  input  logic [19:0] cfg_gap_limit_us,
  // toward the result queue
  input  q_status_t   q_status,
  output logic        push_valid,
  output res_word_t   push_word
);

  phase_t            phase_r, phase_nxt;
  logic [31:0]       last_time_r, last_time_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  count_inc;
  logic [19:0]       gap_limit_r;
  logic [31:0]       delta;
  logic              gap_over;
  logic              accept;
  logic              do_store;
  logic              wr_en;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [QCNT_W:0]   in_flight;

  logic [31:0]       store [BUFFER_DEPTH];
  logic [31:0]       rd_data_r;
  logic              s1_valid_r;
  res_meta_t         s1_meta_r;

  // room check: queue level plus the word in the read stage
  assign in_flight = {1'b0, q_status.level} + (QCNT_W + 1)'(s1_valid_r);
  assign in_full   = in_flight >= (QCNT_W + 1)'(QDEPTH);
  assign accept    = in_push && !in_full;

  assign delta    = in_time_us - last_time_r;
  assign gap_over = delta > {12'd0, gap_limit_r};
  assign count_inc = count_r + CNT_W'(1);

  // read address and range check
  assign rd_addr = ADDR_W'(in_read_index);
  assign rd_ok   = 32'(in_read_index) < 32'(BUFFER_DEPTH);

  // capture state update
  always_comb begin
    phase_nxt     = phase_r;
    last_time_nxt = last_time_r;
    count_nxt     = count_r;
    do_store      = 1'b0;
    if (accept) begin
      case (in_operation)
        OP_EDGE: begin
          if (phase_r == PH_RUNNING) begin
            if (gap_over) begin
              phase_nxt = PH_STOPPED;
            end else begin
              do_store = 1'b1;
            end
          end else if (phase_r == PH_IDLE && !in_pin_level) begin
            phase_nxt = PH_RUNNING;
            do_store  = 1'b1;
          end
        end
        OP_POLL: begin
          if (phase_r == PH_RUNNING && gap_over) begin
            phase_nxt = PH_STOPPED;
          end
        end
        OP_ARM: begin
          phase_nxt     = PH_IDLE;
          count_nxt     = '0;
          last_time_nxt = in_time_us;
        end
        default: begin
        end
      endcase
      // store an interval and stop once the buffer is full
      if (do_store) begin
        last_time_nxt = in_time_us;
        if (32'(count_inc) >= 32'(BUFFER_DEPTH)) begin
          count_nxt = CNT_W'(BUFFER_DEPTH);
          phase_nxt = PH_STOPPED;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  assign wr_en = do_store && (32'(count_r) < 32'(BUFFER_DEPTH));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STOPPED;
      last_time_r <= '0;
      count_r     <= '0;
      gap_limit_r <= GAP_LIMIT_RESET;
      s1_valid_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      last_time_r <= last_time_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= accept;
      if (cfg_we) begin
        gap_limit_r <= cfg_gap_limit_us;
      end
    end
  end

  // interval buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count_r[ADDR_W-1:0]] <= delta;
    end
    if (accept && in_operation == OP_READ) begin
      rd_data_r <= store[rd_addr];
    end
  end

  // result fields alongside the buffer read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r.capture_state <= phase_code(phase_nxt);
      s1_meta_r.entry_count   <= 8'(count_nxt);
      s1_meta_r.done_res      <= (phase_nxt == PH_STOPPED);
      s1_meta_r.is_read       <= (in_operation == OP_READ) && rd_ok;
    end
  end

  // result word to the queue
  assign push_valid              = s1_valid_r;
  assign push_word.capture_state = s1_meta_r.capture_state;
  assign push_word.entry_count   = s1_meta_r.entry_count;
  assign push_word.done_res      = s1_meta_r.done_res;
  assign push_word.read_value    = s1_meta_r.is_read ? rd_data_r : 32'd0;

endmodule

### rtl/ieic_rqueue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieic_rqueue: result queue
// Small first-in first-out queue of result words between the capture
// front end and the result channel.
// ----------------------------------------------------------------------------
module ieic_rqueue import ieic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_word_t push_word,
  input  logic      pop,
  output res_word_t head_word,
  output q_status_t status
);

  res_word_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_word;
    end
  end

  assign head_word    = slots[rd_ptr_r];
  assign status.level = cnt_r;
  assign status.empty = (cnt_r == '0);

endmodule

### rtl/ir_edge_interval_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_edge_interval_capture: infrared edge interval capture
// Records microsecond intervals between receiver edges into a buffer and
// reads them back, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: drive in_* fields with in_push; a word is taken at a clock
//   edge with in_push high and in_full low. Operations are edge, poll, arm
//   and read of a stored interval.
//   result channel: while out_empty is low the oldest result sits on out_*;
//   out_pop high takes it.
//   cfg_we writes the gap limit; write only while no word is in flight.
//   A result word is held in the read stage registers, loaded at the edge that
//   takes its input word, then in the result queue; it shows on out_* as head.
//   Throughput: one word per cycle while in_full is low; the state update of each
//   word finishes in the cycle it is taken, so the next word follows directly.
//   A four-word result queue absorbs stalls; when the receiver stops popping,
//   in_full rises once the queue plus the word in the read stage fill it.
//   Reset: capture stops, count and timestamp clear, gap limit returns to
//   10000 us, the result queue empties. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
module ir_edge_interval_capture import ieic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_time_us,
  input  logic        in_pin_level,
  input  logic [6:0]  in_read_index,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_capture_state,
  output logic [7:0]  out_entry_count,
  output logic        out_done_res,
  output logic [31:0] out_read_value,
  // configuration
  input  logic        cfg_we,
  input  logic [19:0] cfg_gap_limit_us
);

  q_status_t q_status;
  logic      push_valid;
  res_word_t push_word;
  res_word_t head_word;

  // intake, state and buffer
  ieic_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_time_us       (in_time_us),
    .in_pin_level     (in_pin_level),
    .in_read_index    (in_read_index),
    .cfg_we           (cfg_we),
    .cfg_gap_limit_us (cfg_gap_limit_us),
    .q_status         (q_status),
    .push_valid       (push_valid),
    .push_word        (push_word)
  );

  // result queue
  ieic_rqueue u_rqueue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_word (push_word),
    .pop       (out_pop),
    .head_word (head_word),
    .status    (q_status)
  );

  assign out_empty         = q_status.empty;
  assign out_capture_state = head_word.capture_state;
  assign out_entry_count   = head_word.entry_count;
  assign out_done_res      = head_word.done_res;
  assign out_read_value    = head_word.read_value;

endmodule

### rtl/ieic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieic_checker: port-level checks
// Watches the top-level ports for result consistency and queue behavior.
// ----------------------------------------------------------------------------
module ieic_checker import ieic_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_capture_state,
  input logic [7:0]  out_entry_count,
  input logic        out_done_res
);

  // queue is empty right after a reset cycle
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // done flag follows the stopped state
  a_done_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_done_res == (out_capture_state == CS_STOPPED)))
    else $error("done flag disagrees with capture state");

  // count never exceeds the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_entry_count <= 8'(BUFFER_DEPTH)))
    else $error("entry count beyond buffer depth");

  // a waiting word is not dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result word lost");

endmodule

bind ir_edge_interval_capture ieic_checker u_ieic_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_capture_state (out_capture_state),
  .out_entry_count   (out_entry_count),
  .out_done_res      (out_done_res)
);
